[sv/rrr_pkg.sv]
package rrr_pkg;

  localparam int FIELD_W = 24;
  localparam int RATIO_W = 18;
  localparam int CLAMP_W = 31;

  localparam logic CMD_REFLECT = 1'b0;
  localparam logic CMD_REFRACT = 1'b1;

  localparam logic signed [63:0] CLAMP_MAX = 64'sd1073741823;
  localparam logic signed [63:0] CLAMP_MIN = -64'sd1073741824;
  localparam logic signed [63:0] SAT_MAX   = 64'sd8388607;
  localparam logic signed [63:0] SAT_MIN   = -64'sd8388608;

  typedef logic signed [FIELD_W-1:0] coord_t;
  typedef logic signed [CLAMP_W-1:0] clamp_t;
  typedef logic [RATIO_W-1:0]        ratio_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   ok;
  } result_t;

  // round half up, then drop f fraction bits
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int unsigned f);
    rnd = (v + (64'sd1 <<< (f - 1))) >>> f;
  endfunction

  // saturate to the 31-bit intermediate range
  function automatic clamp_t clamp30(input logic signed [63:0] v);
    if (v > CLAMP_MAX) begin
      clamp30 = CLAMP_W'(CLAMP_MAX);
    end else if (v < CLAMP_MIN) begin
      clamp30 = CLAMP_W'(CLAMP_MIN);
    end else begin
      clamp30 = CLAMP_W'(v);
    end
  endfunction

  // saturate to the output field range
  function automatic coord_t sat24(input logic signed [63:0] v);
    if (v > SAT_MAX) begin
      sat24 = FIELD_W'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      sat24 = FIELD_W'(SAT_MIN);
    end else begin
      sat24 = FIELD_W'(v);
    end
  endfunction

endpackage

[sv/rrr_ray_if.sv]
interface rrr_ray_if;
  logic            valid;
  logic            ready;
  logic            command;
  rrr_pkg::coord_t in_x;
  rrr_pkg::coord_t in_y;
  rrr_pkg::coord_t in_z;
  rrr_pkg::coord_t axis_x;
  rrr_pkg::coord_t axis_y;
  rrr_pkg::coord_t axis_z;
  rrr_pkg::ratio_t index_ratio;

  modport source (
    output valid, command, in_x, in_y, in_z, axis_x, axis_y, axis_z, index_ratio,
    input  ready
  );
  modport sink (
    input  valid, command, in_x, in_y, in_z, axis_x, axis_y, axis_z, index_ratio,
    output ready
  );
endinterface

[sv/rrr_res_if.sv]
interface rrr_res_if;
  logic            valid;
  logic            ready;
  rrr_pkg::coord_t out_x;
  rrr_pkg::coord_t out_y;
  rrr_pkg::coord_t out_z;
  logic            ok;

  modport source (
    output valid, out_x, out_y, out_z, ok,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, ok,
    output ready
  );
endinterface

[sv/rrr_delay.sv]
module rrr_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [D];

  // shift line that advances with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int k = 1; k < D; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign q = line[D-1];

endmodule

[sv/rrr_isqrt.sv]
module rrr_isqrt #(
  parameter int W = 62
) (
  input  logic             clk,
  input  logic             en,
  input  logic [W-1:0]     x,
  output logic [W/2-1:0]   root
);

  localparam int N = W / 2;

  logic [W-1:0] rem_q [N];
  logic [W-1:0] res_q [N];

  // one result bit per stage, digit-by-digit square root
  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * j);
    logic [W-1:0] rem_in;
    logic [W-1:0] res_in;
    logic [W-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in = x;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign res_in = res_q[j-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_q[j] <= rem_in - trial;
          res_q[j] <= (res_in >> 1) + BIT;
        end else begin
          rem_q[j] <= rem_in;
          res_q[j] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_q[N-1][N-1:0];

endmodule

[sv/rrr_div.sv]
module rrr_div #(
  parameter int DW = 31,
  parameter int QB = 18
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num_hi,
  input  logic [QB-1:0] num_lo,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  logic [DW-1:0] rem_q [QB];
  logic [QB-1:0] lo_q  [QB];
  logic [DW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QB-1:0] lo_in;
    logic [DW-1:0] den_in;
    logic [QB-1:0] quo_in;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num_hi;
      assign lo_in  = num_lo;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign t  = {rem_in, lo_in[QB-1]};
    assign ge = t >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? DW'(t - {1'b0, den_in}) : t[DW-1:0];
        lo_q[k]  <= lo_in << 1;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QB-2:0], ge};
      end
    end
  end

  assign quo = quo_q[QB-1];

endmodule

[sv/rrr_outbuf.sv]
module rrr_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             arrive_valid,
  input  rrr_pkg::result_t arrive_data,
  output logic             advance,
  rrr_res_if.source        res
);

  logic             out_vld;
  logic             skid_vld;
  rrr_pkg::result_t out_data;
  rrr_pkg::result_t skid_data;
  logic             arrive;
  logic             take;

  assign advance = !skid_vld;
  assign arrive  = arrive_valid && advance;
  assign take    = out_vld && res.ready;

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (take) begin
        skid_vld <= 1'b0;
      end
    end else if (arrive) begin
      if (!out_vld || take) begin
        out_vld <= 1'b1;
      end else begin
        skid_vld <= 1'b1;
      end
    end else if (take) begin
      out_vld <= 1'b0;
    end
  end

  // payload moves without reset
  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (arrive) begin
      if (!out_vld || take) begin
        out_data <= arrive_data;
      end else begin
        skid_data <= arrive_data;
      end
    end
  end

  assign res.valid = out_vld;
  assign res.out_x = out_data.out_x;
  assign res.out_y = out_data.out_y;
  assign res.out_z = out_data.out_z;
  assign res.ok    = out_data.ok;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld) else $error("skid entry held without output entry");
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (arrive && out_vld && !res.ready) |=> skid_vld) else $error("stalled arrival not parked");
  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(out_data)))
    else $error("waiting result changed");
`endif

endmodule

[sv/ray_reflect_refract_unit_core.sv]
// throughput: one transaction per cycle while the output buffer does not stall; depth is set
//   by the two bit-per-stage square root pipelines and the bit-per-stage normalizing divider
// reset: synchronous rst clears the stage valid bits and the output buffer, data is not reset
module ray_reflect_refract_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  rrr_ray_if.sink   ray,
  rrr_res_if.source res
);

  localparam int F    = FRAC_BITS;
  localparam int V    = rrr_pkg::FIELD_W;
  localparam int CW   = rrr_pkg::CLAMP_W;
  localparam int RW   = rrr_pkg::RATIO_W;
  localparam int PW   = 2 * V;
  localparam int SQW  = 2 * V - 1;
  localparam int L2W  = 2 * V;
  localparam int RRW  = 2 * RW;
  localparam int DNW  = CW + V;
  localparam int XW1  = 2 * CW;
  localparam int L1   = XW1 / 2;
  localparam int NW   = V + CW + F;
  localparam int QB   = F + 2;
  localparam int UW   = QB + 1;
  localparam int UNW  = UW + V;
  localparam int DDW  = 2 * CW;
  localparam int WS   = 30 + F + (F % 2);
  localparam int L2   = WS / 2;
  localparam int RPW  = RW + 1 + CW;
  localparam int NRW  = L2 + 1 + V;
  localparam int NV   = 12 + L1 + QB + L2;
  localparam int CHK  = 16;
  localparam int NCH  = L2W / CHK;

  typedef rrr_pkg::coord_t coord_t;
  typedef rrr_pkg::clamp_t clamp_t;
  typedef rrr_pkg::ratio_t ratio_t;

  typedef struct packed {
    logic         cmd;
    logic         zero;
    logic [4:0]   s;
    coord_t [2:0] v;
    coord_t [2:0] n;
    ratio_t       r;
    clamp_t       s2;
    coord_t [2:0] refl;
  } side1_t;

  typedef struct packed {
    logic         cmd;
    logic         zero;
    coord_t [2:0] n;
    ratio_t       r;
    clamp_t       s2;
    coord_t [2:0] refl;
  } carry_t;

  typedef struct packed {
    logic [2:0] neg;
    carry_t     c;
  } side2_t;

  typedef struct packed {
    logic         cmd;
    logic         zero;
    logic         pos;
    clamp_t [2:0] p;
    coord_t [2:0] n;
    ratio_t       r;
    coord_t [2:0] refl;
  } side3_t;

  logic          en;
  logic          accept;
  logic [NV-1:0] vld;

  // valid bits travel with the data
  assign accept    = ray.valid && en;
  assign ray.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], accept};
    end
  end

  // stage 1: products for the reflect dot, squared length and ratio square
  coord_t                 in_v [3];
  coord_t                 in_n [3];
  logic signed [PW-1:0]   sqp  [3];
  logic signed [PW-1:0]   r1_dotp [3];
  logic [SQW-1:0]         r1_sq [3];
  logic [RRW-1:0]         r1_rr;
  coord_t                 r1_v [3];
  coord_t                 r1_n [3];
  ratio_t                 r1_r;
  logic                   r1_cmd;

  assign in_v[0] = ray.in_x;
  assign in_v[1] = ray.in_y;
  assign in_v[2] = ray.in_z;
  assign in_n[0] = ray.axis_x;
  assign in_n[1] = ray.axis_y;
  assign in_n[2] = ray.axis_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqp[i] = PW'(in_v[i]) * PW'(in_v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r1_dotp[i] <= PW'(in_v[i]) * PW'(in_n[i]);
        r1_sq[i]   <= sqp[i][SQW-1:0];
        r1_v[i]    <= in_v[i];
        r1_n[i]    <= in_n[i];
      end
      r1_rr  <= RRW'(ray.index_ratio) * RRW'(ray.index_ratio);
      r1_r   <= ray.index_ratio;
      r1_cmd <= ray.command;
    end
  end

  // stage 2: reflect dot, squared length, ratio square
  clamp_t         r2_d;
  logic [L2W-1:0] r2_l2;
  clamp_t         r2_s2;
  coord_t         r2_v [3];
  coord_t         r2_n [3];
  ratio_t         r2_r;
  logic           r2_cmd;

  always_ff @(posedge clk) begin
    if (en) begin
      r2_d  <= rrr_pkg::clamp30(rrr_pkg::rnd(64'(r1_dotp[0]) + 64'(r1_dotp[1])
                                             + 64'(r1_dotp[2]), F));
      r2_l2 <= L2W'(r1_sq[0]) + L2W'(r1_sq[1]) + L2W'(r1_sq[2]);
      r2_s2 <= rrr_pkg::clamp30(rrr_pkg::rnd(64'(r1_rr), F));
      r2_v  <= r1_v;
      r2_n  <= r1_n;
      r2_r  <= r1_r;
      r2_cmd <= r1_cmd;
    end
  end

  // stage 3: reflect products, leading one per chunk of the length
  logic [NCH-1:0]         nz;
  logic [3:0]             cpos [NCH];
  logic signed [DNW-1:0]  r3_dn [3];
  logic [NCH-1:0]         r3_nz;
  logic [3:0]             r3_pos [NCH];
  logic [L2W-1:0]         r3_l2;
  logic                   r3_zero;
  clamp_t                 r3_s2;
  coord_t                 r3_v [3];
  coord_t                 r3_n [3];
  ratio_t                 r3_r;
  logic                   r3_cmd;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      nz[c]   = |r2_l2[c*CHK +: CHK];
      cpos[c] = '0;
      for (int b = 0; b < CHK; b++) begin
        if (r2_l2[c*CHK + b]) begin
          cpos[c] = 4'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r3_dn[i] <= DNW'(r2_d) * DNW'(r2_n[i]);
      end
      r3_nz   <= nz;
      r3_pos  <= cpos;
      r3_l2   <= r2_l2;
      r3_zero <= (r2_l2 == '0);
      r3_s2   <= r2_s2;
      r3_v    <= r2_v;
      r3_n    <= r2_n;
      r3_r    <= r2_r;
      r3_cmd  <= r2_cmd;
    end
  end

  // stage 4: reflect result, normalizing shift of the squared length
  logic [5:0]     msb;
  logic [5:0]     sdiff;
  logic [4:0]     sh;
  coord_t         refl [3];
  logic [XW1-1:0] r4_x;
  side1_t         r4_side;

  always_comb begin
    if (r3_nz[2]) begin
      msb = {2'b10, r3_pos[2]};
    end else if (r3_nz[1]) begin
      msb = {2'b01, r3_pos[1]};
    end else begin
      msb = {2'b00, r3_pos[0]};
    end
    sdiff = 6'(XW1 - 1) - msb;
    sh    = sdiff[5:1];
    for (int i = 0; i < 3; i++) begin
      refl[i] = rrr_pkg::sat24(rrr_pkg::rnd((64'(r3_v[i]) <<< F)
                                            - (64'(r3_dn[i]) <<< 1), F));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4_x         <= XW1'(r3_l2) << {sh, 1'b0};
      r4_side.cmd  <= r3_cmd;
      r4_side.zero <= r3_zero;
      r4_side.s    <= sh;
      r4_side.r    <= r3_r;
      r4_side.s2   <= r3_s2;
      for (int i = 0; i < 3; i++) begin
        r4_side.v[i]    <= r3_v[i];
        r4_side.n[i]    <= r3_n[i];
        r4_side.refl[i] <= refl[i];
      end
    end
  end

  // length square root
  logic [L1-1:0] q;
  side1_t        d1;

  rrr_isqrt #(.W(XW1)) u_len_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (r4_x),
    .root (q)
  );

  rrr_delay #(.W($bits(side1_t)), .D(L1)) u_side1 (
    .clk (clk),
    .en  (en),
    .d   (r4_side),
    .q   (d1)
  );

  // stage 5: dividend for each component, with half the divisor for rounding
  logic [V-1:0]  mag [3];
  logic [NW-1:0] num [3];
  logic [CW-1:0] r5_hi [3];
  logic [QB-1:0] r5_lo [3];
  logic [CW-1:0] r5_den;
  side2_t        r5_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = $signed(d1.v[i]) < 0 ? V'(-$signed(d1.v[i])) : V'($signed(d1.v[i]));
      num[i] = (NW'(mag[i]) << ({1'b0, d1.s} + 6'(F))) + NW'(q >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r5_hi[i]       <= num[i][QB +: CW];
        r5_lo[i]       <= num[i][QB-1:0];
        r5_side.neg[i] <= d1.v[i][V-1];
        r5_side.c.n[i]    <= d1.n[i];
        r5_side.c.refl[i] <= d1.refl[i];
      end
      r5_den         <= q;
      r5_side.c.cmd  <= d1.cmd;
      r5_side.c.zero <= d1.zero;
      r5_side.c.r    <= d1.r;
      r5_side.c.s2   <= d1.s2;
    end
  end

  // unit direction by division
  logic [QB-1:0] quo [3];
  side2_t        d2;

  for (genvar g = 0; g < 3; g++) begin : g_div
    rrr_div #(.DW(CW), .QB(QB)) u_div (
      .clk    (clk),
      .en     (en),
      .num_hi (r5_hi[g]),
      .num_lo (r5_lo[g]),
      .den    (r5_den),
      .quo    (quo[g])
    );
  end

  rrr_delay #(.W($bits(side2_t)), .D(QB)) u_side2 (
    .clk (clk),
    .en  (en),
    .d   (r5_side),
    .q   (d2)
  );

  // stage 6: signed unit direction and its products with the normal
  logic signed [UW-1:0]  uv [3];
  logic signed [UW-1:0]  r6_uv [3];
  logic signed [UNW-1:0] r6_uvn [3];
  carry_t                r6_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uv[i] = d2.neg[i] ? -$signed(UW'(quo[i])) : $signed(UW'(quo[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r6_uv[i]  <= uv[i];
        r6_uvn[i] <= UNW'(uv[i]) * UNW'($signed(d2.c.n[i]));
      end
      r6_c <= d2.c;
    end
  end

  // stage 7: cosine term
  clamp_t               r7_dt;
  logic signed [UW-1:0] r7_uv [3];
  carry_t               r7_c;

  always_ff @(posedge clk) begin
    if (en) begin
      r7_dt <= rrr_pkg::clamp30(rrr_pkg::rnd(64'(r6_uvn[0]) + 64'(r6_uvn[1])
                                             + 64'(r6_uvn[2]), F));
      r7_uv <= r6_uv;
      r7_c  <= r6_c;
    end
  end

  // stage 8: cosine square and normal scaled by cosine
  logic signed [DDW-1:0] r8_dd;
  logic signed [DNW-1:0] r8_ndt [3];
  logic signed [UW-1:0]  r8_uv [3];
  carry_t                r8_c;

  always_ff @(posedge clk) begin
    if (en) begin
      r8_dd <= DDW'(r7_dt) * DDW'(r7_dt);
      for (int i = 0; i < 3; i++) begin
        r8_ndt[i] <= DNW'($signed(r7_c.n[i])) * DNW'(r7_dt);
      end
      r8_uv <= r7_uv;
      r8_c  <= r7_c;
    end
  end

  // stage 9: sine square term and tangential part
  clamp_t r9_a;
  clamp_t r9_p [3];
  carry_t r9_c;

  always_ff @(posedge clk) begin
    if (en) begin
      r9_a <= rrr_pkg::clamp30(rrr_pkg::rnd((64'sd1 <<< (2 * F)) - 64'(r8_dd), F));
      for (int i = 0; i < 3; i++) begin
        r9_p[i] <= rrr_pkg::clamp30(64'(r8_uv[i]) - rrr_pkg::rnd(64'(r8_ndt[i]), F));
      end
      r9_c <= r8_c;
    end
  end

  // stage 10: ratio square times sine square
  logic signed [DDW-1:0] r10_sa;
  clamp_t                r10_p [3];
  carry_t                r10_c;

  always_ff @(posedge clk) begin
    if (en) begin
      r10_sa <= DDW'(r9_c.s2) * DDW'(r9_a);
      r10_p  <= r9_p;
      r10_c  <= r9_c;
    end
  end

  // stage 11: discriminant and root operand
  clamp_t        disc;
  logic [WS-1:0] r11_x;
  side3_t        r11_side;

  assign disc = rrr_pkg::clamp30((64'sd1 <<< F) - rrr_pkg::rnd(64'(r10_sa), F));

  always_ff @(posedge clk) begin
    if (en) begin
      r11_x         <= (disc > 0) ? (WS'(disc) << F) : '0;
      r11_side.cmd  <= r10_c.cmd;
      r11_side.zero <= r10_c.zero;
      r11_side.pos  <= disc > 0;
      r11_side.r    <= r10_c.r;
      r11_side.n    <= r10_c.n;
      r11_side.refl <= r10_c.refl;
      for (int i = 0; i < 3; i++) begin
        r11_side.p[i] <= r10_p[i];
      end
    end
  end

  // discriminant square root
  logic [L2-1:0] root;
  side3_t        d3;

  rrr_isqrt #(.W(WS)) u_disc_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (r11_x),
    .root (root)
  );

  rrr_delay #(.W($bits(side3_t)), .D(L2)) u_side3 (
    .clk (clk),
    .en  (en),
    .d   (r11_side),
    .q   (d3)
  );

  // stage 12: refracted products
  logic signed [RPW-1:0] r12_rp [3];
  logic signed [NRW-1:0] r12_nr [3];
  logic                  r12_cmd;
  logic                  r12_zero;
  logic                  r12_pos;
  coord_t                r12_refl [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r12_rp[i]   <= RPW'($signed({1'b0, d3.r})) * RPW'($signed(d3.p[i]));
        r12_nr[i]   <= NRW'($signed(d3.n[i])) * NRW'($signed({1'b0, root}));
        r12_refl[i] <= d3.refl[i];
      end
      r12_cmd  <= d3.cmd;
      r12_zero <= d3.zero;
      r12_pos  <= d3.pos;
    end
  end

  // final sum and command select
  coord_t           refr [3];
  rrr_pkg::result_t fin;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      refr[i] = rrr_pkg::sat24(rrr_pkg::rnd(64'(r12_rp[i]) - 64'(r12_nr[i]), F));
    end
    if (r12_cmd == rrr_pkg::CMD_REFLECT) begin
      fin.out_x = r12_refl[0];
      fin.out_y = r12_refl[1];
      fin.out_z = r12_refl[2];
      fin.ok    = 1'b1;
    end else if (!r12_zero && r12_pos) begin
      fin.out_x = refr[0];
      fin.out_y = refr[1];
      fin.out_z = refr[2];
      fin.ok    = 1'b1;
    end else begin
      fin.out_x = '0;
      fin.out_y = '0;
      fin.out_z = '0;
      fin.ok    = 1'b0;
    end
  end

  rrr_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .arrive_valid (vld[NV-1]),
    .arrive_data  (fin),
    .advance      (en),
    .res          (res)
  );

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (!rst && !en) |=> $stable(vld)) else $error("pipeline moved while stalled");
  a_fail_is_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ok) |-> (res.out_x == '0 && res.out_y == '0 && res.out_z == '0))
    else $error("failed refraction with nonzero direction");
  a_reflect_ok: assert property (@(posedge clk) disable iff (rst)
    (vld[NV-1] && r12_cmd == rrr_pkg::CMD_REFLECT) |-> fin.ok)
    else $error("reflect result without ok");
`endif

endmodule
